// ----- design/merkle_mountain_range_ledger_defines.svh -----
// Assertion macros for the ledger checker.
`ifndef MERKLE_MOUNTAIN_RANGE_LEDGER_DEFINES_SVH
`define MERKLE_MOUNTAIN_RANGE_LEDGER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MMR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define MMR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- design/mmr_pkg.sv -----
// Package: types, constants and SHA-256 helpers for the ledger.
package mmr_pkg;
   localparam int PeakSlotsDefault = 64;
   localparam int SealEvery = 1000;
   localparam int SealCntW = 10;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_FINAL  = 2'd1,
      MODE_ROOT   = 2'd2,
      MODE_ROOT3  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_APPENDED = 2'd0,
      ST_REJECTED = 2'd1,
      ST_FINALIZED = 2'd2,
      ST_ROOT     = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] timestamp;
      logic [63:0] event_code;
      logic [63:0] entropy;
      logic [63:0] data_word0;
      logic [63:0] data_word1;
      logic [63:0] data_word2;
      logic [63:0] data_word3;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] root_word0;
      logic [63:0] root_word1;
      logic [63:0] root_word2;
      logic [63:0] root_word3;
      logic [63:0] leaf_total;
      logic        seal_due;
      logic        is_final;
   } rsp_type;

   // Message block source for the hash unit.
   typedef enum logic [2:0] {
      BLK_LEAF,
      BLK_LEAF1,
      BLK_MERGE0,
      BLK_MERGE1,
      BLK_BAG0,
      BLK_BAG1,
      BLK_TAIL
   } blk_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LEAF,
      S_LEAF1,
      S_CLIMB,
      S_RDWAIT,
      S_MERGE0,
      S_MERGE1,
      S_BAGSCAN,
      S_BAGRD,
      S_BAG0,
      S_BAG1,
      S_TAIL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       hash_start;
      logic       hash_init;
      blk_type    blk;
      logic       leaf_done;
      logic       merge_done;
      logic       bag_first;
      logic       bag_done;
      logic       root_done;
      logic       ram_rd;
      logic       slot_inc;
      logic       slot_top;
      logic       slot_dec;
      logic       write_leaf_carry;
      logic       clear_slot;
      logic       finish_append;
      logic       set_final;
      logic       make_rsp;
      status_type rsp_status;
      logic       zero_root;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     hash_busy;
      logic     slot_present;
      logic     slot_last;
      logic     slot_zero;
      logic     sealed;
      logic     empty;
      logic     found;
   } sts_type;

   localparam logic [31:0] KROUND [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [255:0] HINIT = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   // Byte-swap a 64-bit word: little-endian word into message byte order.
   function automatic logic [63:0] bswap(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[63 - 8*i -: 8] = v[8*i +: 8];
      end
      bswap = r;
   endfunction
endpackage

// ----- design/mmr_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module mmr_ram #(
   parameter int Width = 256,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- design/mmr_sha.sv -----
// SHA-256 compression unit, one round per cycle.
module mmr_sha (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         init,
   input  logic [511:0] block,
   output logic         busy,
   output logic [255:0] digest
);
   import mmr_pkg::*;

   logic [255:0] hv_ff, hv_in;
   logic [255:0] wv_ff, wv_in;
   logic [511:0] w_ff, w_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in;

   logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wt, s0, s1, wnew;

   always_comb begin
      {a, b, c, d, e, f, g, h} = wv_ff;
      wt = w_ff[511:480];
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + KROUND[rnd_ff] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      s0 = rotr(w_ff[479:448], 7) ^ rotr(w_ff[479:448], 18) ^ (w_ff[479:448] >> 3);
      s1 = rotr(w_ff[63:32], 17) ^ rotr(w_ff[63:32], 19) ^ (w_ff[63:32] >> 10);
      wnew = w_ff[511:480] + s0 + w_ff[223:192] + s1;
   end

   always_comb begin
      hv_in = hv_ff;
      wv_in = wv_ff;
      w_in = w_ff;
      rnd_in = rnd_ff;
      busy_in = busy_ff;
      if (start) begin
         if (init) begin
            hv_in = HINIT;
            wv_in = HINIT;
         end else begin
            wv_in = hv_ff;
         end
         w_in = block;
         rnd_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         wv_in = {t1 + t2, a, b, c, d + t1, e, f, g};
         w_in = {w_ff[479:0], wnew};
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            busy_in = 1'b0;
            hv_in = {hv_ff[255:224] + t1 + t2, hv_ff[223:192] + a, hv_ff[191:160] + b,
                     hv_ff[159:128] + c, hv_ff[127:96] + d + t1, hv_ff[95:64] + e,
                     hv_ff[63:32] + f, hv_ff[31:0] + g};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      hv_ff <= hv_in;
      wv_ff <= wv_in;
      w_ff <= w_in;
      rnd_ff <= rnd_in;
   end

   assign busy = busy_ff;
   assign digest = hv_ff;
endmodule

// ----- design/mmr_datapath.sv -----
// Ledger datapath: request hold, peak store, slot walk, hash unit and result.
module mmr_datapath #(
   parameter int PeakSlots = mmr_pkg::PeakSlotsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  mmr_pkg::req_type req,
   input  mmr_pkg::cmd_type cmd,
   output mmr_pkg::sts_type sts,
   output mmr_pkg::rsp_type rsp
);
   import mmr_pkg::*;

   localparam int SlotW = $clog2(PeakSlots);

   req_type              req_ff;
   logic [255:0]         carry_ff, carry_in;
   logic [255:0]         run_ff, run_in;
   logic [PeakSlots-1:0] present_ff, present_in;
   logic [63:0]          leaves_ff, leaves_in;
   logic [SealCntW-1:0]  seal_cnt_ff, seal_cnt_in;
   logic                 sealed_ff, sealed_in;
   logic                 found_ff, found_in;
   logic [SlotW-1:0]     slot_ff, slot_in;
   rsp_type              rsp_ff, rsp_in;

   logic [511:0] block;
   logic [255:0] digest, peak_rd, wr_data;
   logic         hash_busy, wr_en;
   logic [63:0]  leaf_total_next;
   logic         seal_next;

   function automatic logic [255:0] peak_rd_msg(input logic [255:0] pw);
      peak_rd_msg = {bswap(pw[255:192]), bswap(pw[191:128]), bswap(pw[127:64]),
                     bswap(pw[63:0])};
   endfunction

   function automatic logic [255:0] peak_msg_to_words(input logic [255:0] m);
      peak_msg_to_words = {bswap(m[255:192]), bswap(m[191:128]), bswap(m[127:64]),
                           bswap(m[63:0])};
   endfunction

   function automatic logic [255:0] to_words_msg(input logic [255:0] dg);
      to_words_msg = {bswap(dg[255:192]), bswap(dg[191:128]), bswap(dg[127:64]),
                      bswap(dg[63:0])};
   endfunction

   always_comb begin
      block = '0;
      case (cmd.blk)
         BLK_LEAF: begin
            block = {bswap(req_ff.timestamp), bswap(req_ff.event_code),
                     bswap(req_ff.entropy), bswap(req_ff.data_word0),
                     bswap(req_ff.data_word1), bswap(req_ff.data_word2),
                     bswap(req_ff.data_word3), 8'h80, 56'h0};
         end
         BLK_LEAF1:  block = {448'h0, 64'd448};
         BLK_MERGE0: block = {peak_rd_msg(peak_rd), carry_ff};
         BLK_MERGE1: block = {8'(slot_ff), 8'h80, 432'h0, 64'd520};
         BLK_BAG0:   block = {run_ff, peak_rd_msg(peak_rd)};
         BLK_BAG1:   block = {8'h80, 440'h0, 64'd512};
         BLK_TAIL:   block = {run_ff, bswap(leaves_ff), 8'h80, 120'h0, 64'd320};
         default:    block = '0;
      endcase
   end

   mmr_sha u_sha (
      .clock (clock),
      .reset (reset),
      .start (cmd.hash_start),
      .init  (cmd.hash_init),
      .block (block),
      .busy  (hash_busy),
      .digest(digest)
   );

   // Store holds word0 in [255:192] .. word3 in [63:0].
   assign wr_en = cmd.write_leaf_carry;
   assign wr_data = peak_msg_to_words(carry_ff);

   mmr_ram #(.Width(256), .Depth(PeakSlots)) u_peaks (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot_ff),
      .wr_data(wr_data),
      .rd_addr(slot_ff),
      .rd_data(peak_rd)
   );

   assign leaf_total_next = leaves_ff + 64'd1;
   // count wrap lands on zero, which is a multiple of the seal period
   assign seal_next = (seal_cnt_ff == SealCntW'(SealEvery - 1)) || (leaves_ff == '1);

   always_comb begin
      carry_in = carry_ff;
      run_in = run_ff;
      present_in = present_ff;
      leaves_in = leaves_ff;
      seal_cnt_in = seal_cnt_ff;
      sealed_in = sealed_ff;
      found_in = found_ff;
      slot_in = slot_ff;
      rsp_in = rsp_ff;
      if (cmd.leaf_done) begin
         carry_in = digest ^ {bswap(req_ff.entropy), 192'h0};
      end
      if (cmd.merge_done) begin
         carry_in = digest;
      end
      if (cmd.clear_slot) begin
         present_in[slot_ff] = 1'b0;
      end
      if (cmd.write_leaf_carry) begin
         present_in[slot_ff] = 1'b1;
      end
      if (cmd.slot_top) begin
         slot_in = SlotW'(PeakSlots - 1);
         found_in = 1'b0;
         run_in = '0;
      end
      if (cmd.slot_inc || cmd.slot_dec) begin
         slot_in = cmd.slot_inc ? slot_ff + SlotW'(1) : slot_ff - SlotW'(1);
      end
      if (cmd.load_req) begin
         slot_in = '0;
      end
      if (cmd.bag_first) begin
         run_in = peak_rd_msg(peak_rd);
         found_in = 1'b1;
      end
      if (cmd.bag_done) begin
         run_in = digest;
      end
      if (cmd.finish_append) begin
         leaves_in = leaf_total_next;
         seal_cnt_in = seal_next ? '0 : seal_cnt_ff + SealCntW'(1);
      end
      if (cmd.set_final) begin
         sealed_in = 1'b1;
      end
      if (cmd.make_rsp) begin
         rsp_in = '0;
         rsp_in.status = cmd.rsp_status;
         rsp_in.leaf_total = cmd.finish_append ? leaf_total_next : leaves_ff;
         rsp_in.seal_due = cmd.finish_append & seal_next;
         rsp_in.is_final = sealed_ff | cmd.set_final;
         if (cmd.root_done && !cmd.zero_root) begin
            {rsp_in.root_word0, rsp_in.root_word1, rsp_in.root_word2,
             rsp_in.root_word3} = to_words_msg(digest);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         leaves_ff <= '0;
         seal_cnt_ff <= '0;
         sealed_ff <= 1'b0;
      end else begin
         present_ff <= present_in;
         leaves_ff <= leaves_in;
         seal_cnt_ff <= seal_cnt_in;
         sealed_ff <= sealed_in;
      end
      if (cmd.load_req) begin
         req_ff <= req;
      end
      carry_ff <= carry_in;
      run_ff <= run_in;
      found_ff <= found_in;
      slot_ff <= slot_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      sts.mode = mode_type'(req_ff.mode);
      sts.hash_busy = hash_busy;
      sts.slot_present = present_ff[slot_ff];
      sts.slot_last = (slot_ff == SlotW'(PeakSlots - 1));
      sts.slot_zero = (slot_ff == '0);
      sts.sealed = sealed_ff;
      sts.empty = (leaves_ff == '0);
      sts.found = found_ff;
   end

   assign rsp = rsp_ff;
endmodule

// ----- design/mmr_ctrl.sv -----
// Ledger controller: sequences leaf hash, peak climb and root bagging.
module mmr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  mmr_pkg::sts_type sts,
   output mmr_pkg::cmd_type cmd
);
   import mmr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_RESP;
         S_RESP: begin
            case (sts.mode)
               MODE_APPEND: state_in = sts.sealed ? S_IDLE : S_LEAF;
               MODE_FINAL:  state_in = S_IDLE;
               default:     state_in = sts.empty ? S_IDLE : S_BAGSCAN;
            endcase
         end
         S_LEAF:   if (!sts.hash_busy) state_in = S_LEAF1;
         S_LEAF1:  if (!sts.hash_busy) state_in = S_CLIMB;
         S_CLIMB:  state_in = sts.slot_present ? S_RDWAIT : S_IDLE;
         S_RDWAIT: state_in = S_MERGE0;
         S_MERGE0: if (!sts.hash_busy) state_in = S_MERGE1;
         S_MERGE1: begin
            if (!sts.hash_busy) state_in = sts.slot_last ? S_IDLE : S_CLIMB;
         end
         S_BAGSCAN: state_in = sts.slot_present ? S_BAGRD : (sts.slot_zero ? S_TAIL : S_BAGSCAN);
         S_BAGRD: begin
            if (!sts.found) state_in = sts.slot_zero ? S_TAIL : S_BAGSCAN;
            else state_in = S_BAG0;
         end
         S_BAG0: if (!sts.hash_busy) state_in = S_BAG1;
         S_BAG1: begin
            if (!sts.hash_busy) state_in = sts.slot_zero ? S_TAIL : S_BAGSCAN;
         end
         S_TAIL: if (!sts.hash_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Hash starts on entry to a hashing state; completion on busy low there.
   logic hash_started_ff, hash_started_in;

   always_comb begin
      cmd = '0;
      cmd.blk = BLK_LEAF;
      cmd.rsp_status = ST_APPENDED;
      hash_started_in = hash_started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.load_req = accept;
      case (state_ff)
         S_RESP: begin
            hash_started_in = 1'b0;
            case (sts.mode)
               MODE_APPEND: begin
                  if (sts.sealed) begin
                     cmd.make_rsp = 1'b1;
                     cmd.rsp_status = ST_REJECTED;
                     rsp_valid_in = 1'b1;
                  end
               end
               MODE_FINAL: begin
                  cmd.set_final = 1'b1;
                  cmd.make_rsp = 1'b1;
                  cmd.rsp_status = ST_FINALIZED;
                  rsp_valid_in = 1'b1;
               end
               default: begin
                  cmd.slot_top = 1'b1;
                  if (sts.empty) begin
                     cmd.make_rsp = 1'b1;
                     cmd.rsp_status = ST_ROOT;
                     cmd.root_done = 1'b1;
                     cmd.zero_root = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               end
            endcase
         end
         S_LEAF, S_LEAF1, S_MERGE0, S_MERGE1, S_BAG0, S_BAG1, S_TAIL: begin
            case (state_ff)
               S_LEAF:   cmd.blk = BLK_LEAF;
               S_LEAF1:  cmd.blk = BLK_LEAF1;
               S_MERGE0: cmd.blk = BLK_MERGE0;
               S_MERGE1: cmd.blk = BLK_MERGE1;
               S_BAG0:   cmd.blk = BLK_BAG0;
               S_BAG1:   cmd.blk = BLK_BAG1;
               default:  cmd.blk = BLK_TAIL;
            endcase
            cmd.hash_init = (state_ff != S_LEAF1) && (state_ff != S_MERGE1)
                            && (state_ff != S_BAG1);
            if (!hash_started_ff) begin
               cmd.hash_start = 1'b1;
               hash_started_in = 1'b1;
            end else if (!sts.hash_busy) begin
               hash_started_in = 1'b0;
               case (state_ff)
                  S_LEAF1: cmd.leaf_done = 1'b1;
                  S_MERGE1: begin
                     cmd.merge_done = 1'b1;
                     cmd.clear_slot = 1'b1;
                     if (sts.slot_last) begin
                        cmd.finish_append = 1'b1;
                        cmd.make_rsp = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        cmd.slot_inc = 1'b1;
                     end
                  end
                  S_BAG1: begin
                     cmd.bag_done = 1'b1;
                     if (!sts.slot_zero) cmd.slot_dec = 1'b1;
                  end
                  S_TAIL: begin
                     cmd.root_done = 1'b1;
                     cmd.make_rsp = 1'b1;
                     cmd.rsp_status = ST_ROOT;
                     rsp_valid_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_CLIMB: begin
            if (!sts.slot_present) begin
               cmd.write_leaf_carry = 1'b1;
               cmd.finish_append = 1'b1;
               cmd.make_rsp = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         S_BAGSCAN: begin
            if (!sts.slot_present && !sts.slot_zero) cmd.slot_dec = 1'b1;
         end
         S_BAGRD: begin
            if (!sts.found) begin
               cmd.bag_first = 1'b1;
               if (!sts.slot_zero) cmd.slot_dec = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Hash state sequencing relies on the busy flag being set in the cycle after start.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         hash_started_ff <= 1'b0;
      end else begin
         state_ff <= (state_ff inside {S_LEAF, S_LEAF1, S_MERGE0, S_MERGE1, S_BAG0, S_BAG1,
                                       S_TAIL}
                      && (!hash_started_ff || sts.hash_busy)) ? state_ff : state_in;
         rsp_valid_ff <= rsp_valid_in;
         hash_started_ff <= hash_started_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- design/merkle_mountain_range_ledger.sv -----
// Top level of the Merkle mountain range audit ledger.
// Usage:
//   req channel (valid/ready) carries one transaction: mode, leaf fields and data.
//   rsp channel (valid/ready) returns exactly one transaction per request.
//   Each SHA-256 compression runs in the one-round-per-cycle unit.
//   Append: two compressions for the leaf, then a slot read plus two
//   compressions for each occupied peak slot it merges through; the number of
//   such slots is the count of trailing ones of the leaf count.
//   Root read: a scan of the slots down from the top with a read of each present
//   peak, two compressions per present peak below the highest, and one final
//   compression.
//   Finalize, rejected appends and an empty root read answer from the S_RESP
//   state through the registered rsp_valid, with no hashing.
//   One transaction is processed at a time; req_ready is low while busy or while
//   a result is held.
//   Reset clears the peak-present bits, the leaf count and the final flag;
//   peak store contents need no clearing.
//   When the receiver stalls, the result holds in the output register.
module merkle_mountain_range_ledger #(
   parameter int PeakSlots = mmr_pkg::PeakSlotsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mmr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mmr_pkg::rsp_type rsp_data
);
   import mmr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mmr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   mmr_datapath #(.PeakSlots(PeakSlots)) u_dp (
      .clock(clock),
      .reset(reset),
      .req  (req_data),
      .cmd  (cmd),
      .sts  (sts),
      .rsp  (rsp_data)
   );
endmodule

// ----- design/mmr_checker.sv -----
// Port-level checker for the ledger, bound to the top level.
`include "merkle_mountain_range_ledger_defines.svh"
module mmr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mmr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mmr_pkg::rsp_type rsp_data
);
   import mmr_pkg::*;

   `MMR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")
   `MMR_ASSERT_IMP(a_no_accept_with_rsp, clock, reset, rsp_valid, !req_ready, "request taken while result pending")
   `MMR_ASSERT_IMP(a_reject_final, clock, reset, rsp_valid && (rsp_data.status == ST_REJECTED || rsp_data.status == ST_FINALIZED), rsp_data.is_final, "final flag missing")
   `MMR_ASSERT_IMP(a_seal_only_append, clock, reset, rsp_valid && rsp_data.seal_due, rsp_data.status == ST_APPENDED, "seal flag on non-append")
endmodule

bind merkle_mountain_range_ledger mmr_checker u_mmr_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

// ----- dv/tb_merkle_mountain_range_ledger.sv -----
// Testbench for the Merkle mountain range ledger: directed table plus random traffic.
`timescale 1ns / 100ps
module tb_merkle_mountain_range_ledger;
   import mmr_pkg::*;

   localparam int NumPeaks = 64;
   localparam longint CycleLimit = 10000000;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type       pending_rsp[$];
   int            mismatches = 0;
   longint        cycles = 0;
   bit            idle_on;
   bit            hold_req;
   logic [255:0]  peak_digest[NumPeaks];
   logic [63:0]   peak_bits;
   logic [63:0]   leaves;
   bit            is_sealed;
   dir_row_type   dir_rows[$];

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   localparam logic [31:0] InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   merkle_mountain_range_ledger dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // little-endian word into message byte order
   function automatic logic [63:0] le_bytes(logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) r[63 - 8*i -: 8] = v[8*i +: 8];
      return r;
   endfunction

   // msg byte 0 at the top bits; bytes past len must be zero
   function automatic logic [255:0] sha256_of(logic [1023:0] msg, int len);
      logic [1023:0] blkbuf;
      logic [31:0] hs[8];
      logic [31:0] w[64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      int nblk;
      blkbuf = msg;
      blkbuf[1023 - 8*len -: 8] = 8'h80;
      nblk = (len + 9 <= 64) ? 1 : 2;
      blkbuf[1024 - 512*nblk +: 64] = 64'(len) * 64'd8;
      for (int i = 0; i < 8; i++) hs[i] = InitH[i];
      for (int blk = 0; blk < nblk; blk++) begin
         for (int i = 0; i < 16; i++) w[i] = blkbuf[1023 - 512*blk - 32*i -: 32];
         for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         a = hs[0]; b = hs[1]; c = hs[2]; d = hs[3];
         e = hs[4]; f = hs[5]; g = hs[6]; h = hs[7];
         for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + RoundK[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         hs[0] += a; hs[1] += b; hs[2] += c; hs[3] += d;
         hs[4] += e; hs[5] += f; hs[6] += g; hs[7] += h;
      end
      return {hs[0], hs[1], hs[2], hs[3], hs[4], hs[5], hs[6], hs[7]};
   endfunction

   function automatic rsp_type ledger_predict(req_type r);
      rsp_type o;
      logic [1023:0] m;
      logic [255:0] carry, run, root;
      bit found;
      o = '0;
      root = '0;
      case (mode_type'(r.mode))
         MODE_APPEND: begin
            if (is_sealed) begin
               o.status = ST_REJECTED;
            end else begin
               m = '0;
               m[1023 -: 448] = {le_bytes(r.timestamp), le_bytes(r.event_code),
                                 le_bytes(r.entropy), le_bytes(r.data_word0),
                                 le_bytes(r.data_word1), le_bytes(r.data_word2),
                                 le_bytes(r.data_word3)};
               carry = sha256_of(m, 56);
               carry[255 -: 64] ^= le_bytes(r.entropy);
               for (int h = 0; h < NumPeaks; h++) begin
                  if (!peak_bits[h]) begin
                     peak_digest[h] = carry;
                     peak_bits[h] = 1'b1;
                     break;
                  end
                  m = '0;
                  m[1023 -: 520] = {peak_digest[h], carry, 8'(h)};
                  carry = sha256_of(m, 65);
                  peak_bits[h] = 1'b0;
               end
               leaves++;
               o.status = ST_APPENDED;
               o.seal_due = (leaves % 64'd1000 == 0);
            end
         end
         MODE_FINAL: begin
            is_sealed = 1'b1;
            o.status = ST_FINALIZED;
         end
         default: begin
            o.status = ST_ROOT;
            if (leaves != 0) begin
               run = '0;
               found = 0;
               for (int h = NumPeaks - 1; h >= 0; h--) begin
                  if (peak_bits[h]) begin
                     if (!found) begin
                        run = peak_digest[h];
                        found = 1;
                     end else begin
                        m = '0;
                        m[1023 -: 512] = {run, peak_digest[h]};
                        run = sha256_of(m, 64);
                     end
                  end
               end
               m = '0;
               m[1023 -: 320] = {run, le_bytes(leaves)};
               root = sha256_of(m, 40);
            end
         end
      endcase
      o.root_word0 = le_bytes(root[255 -: 64]);
      o.root_word1 = le_bytes(root[191 -: 64]);
      o.root_word2 = le_bytes(root[127 -: 64]);
      o.root_word3 = le_bytes(root[63 -: 64]);
      o.leaf_total = leaves;
      o.is_final = is_sealed;
      return o;
   endfunction

   function automatic req_type make_req(mode_type md, logic [63:0] ts, logic [63:0] code,
                                        logic [63:0] ent, logic [63:0] d0, logic [63:0] d1,
                                        logic [63:0] d2, logic [63:0] d3);
      req_type r;
      r.mode = md;
      r.timestamp = ts; r.event_code = code; r.entropy = ent;
      r.data_word0 = d0; r.data_word1 = d1; r.data_word2 = d2; r.data_word3 = d3;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_type rand_req(mode_type md);
      return make_req(md, rand64(), ($urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 400))),
                      rand64(), rand64(), rand64(), rand64(), rand64());
   endfunction

   task automatic add_row(req_type r, bit known, rsp_type e);
      dir_row_type row;
      row.req = r; row.known = known; row.rsp = e;
      dir_rows.push_back(row);
   endtask

   task automatic send_req(req_type r);
      bit rdy;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_data = r;
      req_valid = 1'b1;
      forever begin
         rdy = req_ready;
         @(posedge clock);
         if (rdy) break;
         @(negedge clock);
      end
      pending_rsp.push_back(ledger_predict(r));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic check_rsp(rsp_type got);
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected transaction: %p", got);
         return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status || got.root_word0 !== want.root_word0 ||
          got.root_word1 !== want.root_word1 || got.root_word2 !== want.root_word2 ||
          got.root_word3 !== want.root_word3 || got.leaf_total !== want.leaf_total ||
          got.seal_due !== want.seal_due || got.is_final !== want.is_final) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch at cycle %0d", cycles);
            $display("  exp %p", want);
            $display("  got %p", got);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side
   initial begin
      int stall_left;
      int hold_cnt;
      bit v;
      rsp_type d;
      stall_left = 0;
      hold_cnt = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            hold_cnt = 600;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
         v = rsp_valid;
         d = rsp_data;
         @(posedge clock);
         if (!reset && v && rsp_ready) check_rsp(d);
      end
   end

   // request side
   initial begin
      rsp_type empty_rsp;
      int n;
      mode_type md;
      idle_on = 1;
      hold_req = 0;
      peak_bits = '0;
      leaves = '0;
      is_sealed = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      empty_rsp = '0;
      empty_rsp.status = ST_ROOT;
      add_row(make_req(MODE_ROOT, '0, '0, '0, '0, '0, '0, '0), 1, empty_rsp);
      add_row(make_req(MODE_ROOT3, '1, '1, '1, '1, '1, '1, '1), 1, empty_rsp);
      add_row(make_req(MODE_APPEND, '0, '0, '0, '0, '0, '0, '0), 0, empty_rsp);
      add_row(make_req(MODE_ROOT, '0, '0, '0, '0, '0, '0, '0), 0, empty_rsp);
      add_row(make_req(MODE_APPEND, '1, '1, '1, '1, '1, '1, '1), 0, empty_rsp);
      add_row(make_req(MODE_ROOT, '0, '0, '0, '0, '0, '0, '0), 0, empty_rsp);
      add_row(make_req(MODE_APPEND, '1, '0, '0, '0, '0, '0, '0), 0, empty_rsp);
      add_row(make_req(MODE_ROOT3, '0, '0, '0, '0, '0, '0, '0), 0, empty_rsp);
      add_row(make_req(MODE_APPEND, {32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}},
                       {32{2'b10}}, {32{2'b01}}, {32{2'b10}}), 0, empty_rsp);
      add_row(make_req(MODE_ROOT, '0, '0, '0, '0, '0, '0, '0), 0, empty_rsp);
      add_row(make_req(MODE_APPEND, '0, 64'd59, '1, '0, '1, '0, '1), 0, empty_rsp);
      add_row(make_req(MODE_APPEND, 64'd1, '0, 64'h8000_0000_0000_0001, '1, '0, '1, '0),
              0, empty_rsp);
      add_row(make_req(MODE_ROOT, '0, '0, '0, '0, '0, '0, '0), 0, empty_rsp);
      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].req);
         if (dir_rows[i].known) pending_rsp[$] = dir_rows[i].rsp;
      end
      drain_results();

      // random traffic
      n = 0;
      while (n < 380) begin
         n++;
         if (n == 150) hold_req = 1;
         if (n == 250) drain_results();
         if (n > 320) idle_on = 0;
         md = ($urandom_range(0, 99) < 78) ? MODE_APPEND
              : ($urandom_range(0, 1) ? MODE_ROOT : MODE_ROOT3);
         send_req(rand_req(md));
      end

      // finalize, then rejected appends, root reads and repeated finalize
      send_req(rand_req(MODE_FINAL));
      send_req(rand_req(MODE_APPEND));
      send_req(rand_req(MODE_ROOT));
      send_req(rand_req(MODE_FINAL));
      send_req(rand_req(MODE_APPEND));
      send_req(rand_req(MODE_ROOT3));
      req_valid = 1'b0;

      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+design
design/mmr_pkg.sv
design/mmr_ram.sv
design/mmr_sha.sv
design/mmr_datapath.sv
design/mmr_ctrl.sv
design/merkle_mountain_range_ledger.sv
design/mmr_checker.sv
dv/tb_merkle_mountain_range_ledger.sv
